>>> rtl/skt_pkg.sv
`default_nettype none

package skt_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BEYOND    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_DONE
  } state_t;

  localparam int unsigned KEY_BITS      = 32;
  localparam int unsigned POSITION_BITS = 6;
  localparam int unsigned COUNT_BITS    = 7;

endpackage

`default_nettype wire

>>> rtl/skt_if.sv
`default_nettype none

interface skt_in_if;
  logic                                valid;
  logic                                ready;
  skt_pkg::opcode_t                    opcode;
  logic [skt_pkg::KEY_BITS-1:0]        key;
  logic [skt_pkg::POSITION_BITS-1:0]   position;

  modport source (output valid, output opcode, output key, output position, input ready);
  modport sink   (input valid, input opcode, input key, input position, output ready);
endinterface

interface skt_out_if;
  logic                                valid;
  logic                                ready;
  skt_pkg::status_t                    status;
  logic [skt_pkg::KEY_BITS-1:0]        item_key;
  logic [skt_pkg::COUNT_BITS-1:0]      entry_count;

  modport source (output valid, output status, output item_key, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input item_key, input entry_count,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/skt_key_mem.sv
`default_nettype none

module skt_key_mem #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned KEY_WIDTH = 32,
  parameter int unsigned AW        = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic [KEY_WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]        rd_addr,
  output logic      [KEY_WIDTH-1:0] rd_data
);

  logic [KEY_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/sorted_key_table.sv
// channel   dir   handshake      payload
// in_ch     in    valid/ready    opcode, key, position
// out_ch    out   valid/ready    status, item_key, entry_count
// cfg       in    cfg_we         cfg_data (order_descending)
//
// insert and remove walk the key memory front to back, one entry a cycle through
// its single read and write port, up to the number of keys held; read fetches one entry;
// a read beyond the end, a full insert or an unused opcode goes straight to the result
// one item at a time; the next item is taken while the result waits on out_ch
// reset (rst_n low, synchronous) empties the table and sets ascending order
`default_nettype none

module sorted_key_table #(
  parameter int unsigned DEPTH     = 64,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  skt_in_if.sink     in_ch,
  skt_out_if.source  out_ch,
  input  wire logic  cfg_we,
  input  wire logic  cfg_data
);

  import skt_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  state_t state_r, state_nxt;

  opcode_t              op_r, op_nxt;
  logic [KEY_WIDTH-1:0] key_r, key_nxt;
  logic [KEY_WIDTH-1:0] carry_r, carry_nxt;
  logic                 found_r, found_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic                 desc_r;
  status_t              res_status_r, res_status_nxt;
  logic [KEY_BITS-1:0]  res_item_r, res_item_nxt;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [KEY_BITS-1:0]   out_item_r, out_item_nxt;
  logic [COUNT_BITS-1:0] out_count_r, out_count_nxt;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [KEY_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [KEY_WIDTH-1:0] mem_rdata;

  logic                 in_fire;
  logic                 out_free;
  logic                 scan_end;
  logic                 stops;
  logic                 equal;
  logic                 full;
  logic                 beyond;
  logic [CW-1:0]        idx_inc;
  logic [CW-1:0]        idx_dec;
  logic [KEY_WIDTH-1:0] in_key_w;
  logic [KEY_BITS-1:0]  rd_key_out;
  logic [KEY_WIDTH+KEY_BITS-1:0]    key_in_ext;
  logic [KEY_WIDTH+KEY_BITS-1:0]    key_out_ext;
  logic [CW+POSITION_BITS-1:0]      pos_ext;
  logic [CW+POSITION_BITS-1:0]      cnt_ext;
  logic [CW+COUNT_BITS-1:0]         cnt_out_ext;

  skt_key_mem #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // width adaptation between the 32-bit ports and the stored key width
  assign key_in_ext  = {{KEY_WIDTH{1'b0}}, in_ch.key};
  assign in_key_w    = key_in_ext[KEY_WIDTH-1:0];
  assign key_out_ext = {{KEY_BITS{1'b0}}, mem_rdata};
  assign rd_key_out  = key_out_ext[KEY_BITS-1:0];
  assign pos_ext     = {{CW{1'b0}}, in_ch.position};
  assign cnt_ext     = {{POSITION_BITS{1'b0}}, count_r};
  assign cnt_out_ext = {{COUNT_BITS{1'b0}}, count_r};

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign idx_inc  = idx_r + 1'b1;
  assign idx_dec  = idx_r - 1'b1;
  assign scan_end = (idx_r == count_r);
  assign full     = (count_r == CW'(DEPTH));
  assign beyond   = (pos_ext >= cnt_ext);
  assign stops    = desc_r ? (mem_rdata <= key_r) : (mem_rdata >= key_r);
  assign equal    = (mem_rdata == key_r);

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.item_key    = out_item_r;
  assign out_ch.entry_count = out_count_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.opcode)
            OP_INSERT: state_nxt = full ? S_DONE : S_SCAN;
            OP_REMOVE: state_nxt = S_SCAN;
            OP_READ:   state_nxt = beyond ? S_DONE : S_READ;
            default:   state_nxt = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    op_nxt         = op_r;
    key_nxt        = key_r;
    carry_nxt      = carry_r;
    found_nxt      = found_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_item_nxt   = res_item_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_item_nxt   = out_item_r;
    out_count_nxt  = out_count_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r[AW-1:0];
    mem_wdata      = carry_r;
    mem_raddr      = idx_inc[AW-1:0];

    case (state_r)
      S_IDLE: begin
        mem_raddr = '0;
        if (in_fire) begin
          op_nxt         = in_ch.opcode;
          key_nxt        = in_key_w;
          found_nxt      = 1'b0;
          idx_nxt        = '0;
          res_status_nxt = ST_OK;
          res_item_nxt   = '0;
          case (in_ch.opcode)
            OP_INSERT: begin
              if (full) begin
                res_status_nxt = ST_FULL;
              end
            end
            OP_READ: begin
              mem_raddr = pos_ext[AW-1:0];
              if (beyond) begin
                res_status_nxt = ST_BEYOND;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        idx_nxt = idx_inc;
        if (op_r == OP_INSERT) begin
          if (scan_end) begin
            mem_we    = 1'b1;
            mem_wdata = found_r ? carry_r : key_r;
            count_nxt = count_r + 1'b1;
          end else if (!found_r && stops) begin
            mem_we    = 1'b1;
            mem_wdata = key_r;
            carry_nxt = mem_rdata;
            found_nxt = 1'b1;
          end else if (found_r) begin
            mem_we    = 1'b1;
            mem_wdata = carry_r;
            carry_nxt = mem_rdata;
          end
        end else begin
          if (scan_end) begin
            if (found_r) begin
              count_nxt = count_r - 1'b1;
            end else begin
              res_status_nxt = ST_NOT_FOUND;
            end
          end else if (!found_r && equal) begin
            found_nxt = 1'b1;
          end else if (found_r) begin
            // close the gap: entry moves one place toward the front
            mem_we    = 1'b1;
            mem_waddr = idx_dec[AW-1:0];
            mem_wdata = mem_rdata;
          end
        end
      end
      S_READ: begin
        res_item_nxt = rd_key_out;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_item_nxt   = res_item_r;
          out_count_nxt  = cnt_out_ext[COUNT_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      desc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        desc_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    carry_r      <= carry_nxt;
    found_r      <= found_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_item_r   <= res_item_nxt;
    out_status_r <= out_status_nxt;
    out_item_r   <= out_item_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule

`default_nettype wire
